/* rtl/repeating_key_letter_cipher_unit_defines.svh */
// Assertion macros for the checker file of the cipher unit.
`ifndef REPEATING_KEY_LETTER_CIPHER_UNIT_DEFINES_SVH
`define REPEATING_KEY_LETTER_CIPHER_UNIT_DEFINES_SVH

// Property checked outside reset.
`define VKC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cipher unit assertion failed");

// Property checked on every edge, reset included.
`define VKC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("cipher unit assertion failed");

`endif

/* rtl/vkc_pkg.sv */
// ----------------------------------------------------------------------------
// vkc_pkg
// Shared types and constants of the repeating-key letter cipher unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vkc_pkg;

   localparam int KEY_MAX    = 12;
   localparam int LETTER_W   = 5;
   localparam int KEY_W      = KEY_MAX * LETTER_W;
   localparam int POS_W      = 4;
   localparam int LEN_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int OUT_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;
   localparam int FIFO_CNT_W = 2;

   localparam logic [LETTER_W-1:0] ALPHA = 5'd26;

   localparam logic [BYTE_W-1:0] ASCII_UP_A = 8'h41;
   localparam logic [BYTE_W-1:0] ASCII_UP_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] ASCII_LO_A = 8'h61;
   localparam logic [BYTE_W-1:0] ASCII_LO_Z = 8'h7A;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_LETTERS  = 2'd0,
      CSR_KEY_LENGTH   = 2'd1,
      CSR_DECRYPT_MODE = 2'd2
   } csr_index_type;

   // One classified letter waiting for the shift stage.
   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic [LETTER_W-1:0] key;
      logic                decrypt;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // Fold a key letter 26..31 back into 0..5.
   function automatic logic [LETTER_W-1:0] reduce_key(input logic [LETTER_W-1:0] k);
      return (k >= ALPHA) ? LETTER_W'(k - ALPHA) : k;
   endfunction

endpackage

`default_nettype wire

/* rtl/vkc_fifo.sv */
// ----------------------------------------------------------------------------
// vkc_fifo
// Short queue of classified letters between the front and back stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vkc_fifo
   import vkc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire entry_type       wr_entry,
   input  wire logic            pop,
   output entry_type            rd_entry,
   output fifo_status_type      status
);

   entry_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]    count_ff, count_in;
   logic                     do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? FIFO_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? FIFO_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = FIFO_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = FIFO_CNT_W'(count_ff - 1'b1);
      end
      rd_entry     = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/vkc_front.sv */
// ----------------------------------------------------------------------------
// vkc_front
// Holds the key registers, classifies bytes and tracks the key position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vkc_front
   import vkc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [KEY_W-1:0]     csr_wdata,
   input  wire logic                 req_push,
   input  wire logic [BYTE_W-1:0]    req_in_byte,
   input  wire logic                 req_message_start,
   input  wire logic                 q_full,
   output logic                      q_push,
   output entry_type                 q_entry
);

   logic [KEY_W-1:0]    key_letters_ff;
   logic [LEN_W-1:0]    key_length_ff;
   logic                decrypt_mode_ff;
   logic [POS_W-1:0]    pos_ff, pos_in;

   logic [LETTER_W-1:0] key_arr [KEY_MAX];
   logic                accept, is_upper, is_lower, is_letter;
   logic [BYTE_W-1:0]   offset;
   logic [LEN_W-1:0]    len_use;
   logic [POS_W-1:0]    pos_base, pos_eff, pos_inc, pos_next;

   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < KEY_MAX; i++) begin
         key_arr[i] = key_letters_ff[i*LETTER_W +: LETTER_W];
      end
      accept    = req_push && !q_full;
      is_upper  = (req_in_byte >= ASCII_UP_A) && (req_in_byte <= ASCII_UP_Z);
      is_lower  = (req_in_byte >= ASCII_LO_A) && (req_in_byte <= ASCII_LO_Z);
      is_letter = is_upper || is_lower;
      offset    = is_upper ? BYTE_W'(req_in_byte - ASCII_UP_A)
                           : BYTE_W'(req_in_byte - ASCII_LO_A);

      // Clamp the key length into 1..KEY_MAX.
      if (key_length_ff == '0) begin
         len_use = LEN_W'(1);
      end else if (key_length_ff > LEN_W'(KEY_MAX)) begin
         len_use = LEN_W'(KEY_MAX);
      end else begin
         len_use = key_length_ff;
      end

      pos_base = req_message_start ? '0 : pos_ff;
      // Restart at letter zero when the length shrank under the position.
      pos_eff  = (pos_base >= len_use) ? '0 : pos_base;
      pos_inc  = POS_W'(pos_eff + 1'b1);
      pos_next = (pos_inc >= len_use) ? '0 : pos_inc;

      pos_in = pos_ff;
      if (accept) begin
         pos_in = is_letter ? pos_next : pos_base;
      end

      q_push          = accept && is_letter;
      q_entry.letter  = offset[LETTER_W-1:0];
      q_entry.key     = reduce_key(key_arr[pos_eff]);
      q_entry.decrypt = decrypt_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_letters_ff  <= '0;
         key_length_ff   <= LEN_W'(1);
         decrypt_mode_ff <= 1'b0;
         pos_ff          <= '0;
      end else begin
         pos_ff <= pos_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_KEY_LETTERS) begin
               key_letters_ff <= csr_wdata;
            end
            if (csr_index == CSR_KEY_LENGTH) begin
               key_length_ff <= csr_wdata[LEN_W-1:0];
            end
            if (csr_index == CSR_DECRYPT_MODE) begin
               decrypt_mode_ff <= csr_wdata[0];
            end
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/vkc_back.sv */
// ----------------------------------------------------------------------------
// vkc_back
// Shifts each queued letter by its key letter and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vkc_back
   import vkc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fifo_status_type   q_status,
   input  wire entry_type         q_entry,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [OUT_W-1:0]       rsp_out_byte
);

   localparam int SUM_W = LETTER_W + 1;

   logic               out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]   out_byte_ff, out_byte_in;
   logic [SUM_W-1:0]   sum, shifted;

   always_comb begin
      // Decrypt adds 26 first so the difference never goes negative.
      if (q_entry.decrypt) begin
         sum = SUM_W'({1'b0, q_entry.letter} + {1'b0, ALPHA} - {1'b0, q_entry.key});
      end else begin
         sum = SUM_W'({1'b0, q_entry.letter} + {1'b0, q_entry.key});
      end
      shifted = (sum >= {1'b0, ALPHA}) ? SUM_W'(sum - {1'b0, ALPHA}) : sum;

      // Advance when the output register is free or being drained.
      q_pop        = !q_status.empty && (!out_valid_ff || rsp_pop);
      out_valid_in = q_pop || (out_valid_ff && !rsp_pop);
      out_byte_in  = q_pop ? OUT_W'(ASCII_LO_A[OUT_W-1:0] + OUT_W'(shifted)) : out_byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;

endmodule

`default_nettype wire

/* rtl/repeating_key_letter_cipher_unit.sv */
// ----------------------------------------------------------------------------
// repeating_key_letter_cipher_unit
// Repeating-key letter cipher over a stream of ASCII bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue: drive req_in_byte / req_message_start with
//   req_push; the byte is taken on an edge where req_full is low.
//   Non-letters are dropped; message_start restarts the key at letter zero.
//   Response side is a queue: rsp_out_byte is valid while rsp_empty is low
//   and is consumed on an edge with rsp_pop high.
//   Key registers are written through csr_valid/csr_index/csr_wdata;
//   csr_ready is always high. Write only while the unit is idle.
// Timing:
//   A letter taken is written into the queue and moves into the output
//   register when that register is free. One byte per cycle is sustained
//   while the receiver pops; the front stage (classify and key position
//   counter) and the back stage (mod-26 add) are joined by a two-entry queue.
// Reset clears the key position and queue and loads key length 1, key
// letters 0 and encrypt mode. When the receiver stalls, the output register
// and queue fill, then req_full rises until rsp_pop drains a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module repeating_key_letter_cipher_unit
   import vkc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [KEY_W-1:0]     csr_wdata,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [BYTE_W-1:0]    req_in_byte,
   input  wire logic                 req_message_start,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [OUT_W-1:0]          rsp_out_byte
);

   fifo_status_type q_status;
   entry_type       q_wr_entry, q_rd_entry;
   logic            q_push, q_pop;

   assign req_full = q_status.full;

   vkc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_push          (req_push),
      .req_in_byte       (req_in_byte),
      .req_message_start (req_message_start),
      .q_full            (q_status.full),
      .q_push            (q_push),
      .q_entry           (q_wr_entry)
   );

   vkc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (q_wr_entry),
      .pop      (q_pop),
      .rd_entry (q_rd_entry),
      .status   (q_status)
   );

   vkc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .q_entry      (q_rd_entry),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule

`default_nettype wire

/* rtl/vkc_checker.sv */
// ----------------------------------------------------------------------------
// vkc_checker
// Port-level checks of the cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "repeating_key_letter_cipher_unit_defines.svh"

module vkc_checker
   import vkc_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 csr_valid,
   input wire logic                 csr_ready,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [KEY_W-1:0]     csr_wdata,
   input wire logic                 req_push,
   input wire logic                 req_full,
   input wire logic [BYTE_W-1:0]    req_in_byte,
   input wire logic                 req_message_start,
   input wire logic                 rsp_empty,
   input wire logic                 rsp_pop,
   input wire logic [OUT_W-1:0]     rsp_out_byte
);

   // Queue and output register come out of reset drained.
   `VKC_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> rsp_empty && !req_full)

   // Results are always lower-case letters.
   `VKC_ASSERT(a_out_lower, clock, reset, !rsp_empty |-> (rsp_out_byte >= 7'h61) && (rsp_out_byte <= 7'h7A))

   // A waiting result holds until it is popped.
   `VKC_ASSERT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_byte))

   // Back pressure needs a stalled result: full only behind a waiting output.
   `VKC_ASSERT(a_full_needs_rsp, clock, reset, req_full |-> !rsp_empty)

endmodule

bind repeating_key_letter_cipher_unit vkc_checker u_vkc_checker (.*);

`default_nettype wire

/* tb/tb_repeating_key_letter_cipher_unit.sv */
// ----------------------------------------------------------------------------
// tb_repeating_key_letter_cipher_unit
// Self-checking bench for the repeating-key letter cipher unit. A short table
// of directed bytes and key settings runs first, then random messages under
// several key settings. A local predictor tracks the key position and the
// registers, and every popped letter is checked in order against it or the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_repeating_key_letter_cipher_unit;
   import vkc_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int SETTLE       = 4;
   localparam int PHASES       = 8;
   localparam int PHASE_LETTERS = 92;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // key letters 0..3 are 25, 1, 31, 26; the rest count up from 4
   localparam logic [KEY_W-1:0] KEY_MIX = {5'd11, 5'd10, 5'd9, 5'd8, 5'd7, 5'd6,
                                           5'd5, 5'd4, 5'd26, 5'd31, 5'd1, 5'd25};
   localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

   typedef struct packed {
      logic                 is_write;
      logic [CSR_IDX_W-1:0] idx;
      logic [KEY_W-1:0]     wdata;
      logic [BYTE_W-1:0]    in_byte;
      logic                 start;
      logic                 typed;
      logic                 yields;
      logic [OUT_W-1:0]     out_byte;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_KEY_LETTERS;
   logic [KEY_W-1:0]     csr_wdata = '0;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [BYTE_W-1:0]    req_in_byte = '0;
   logic                 req_message_start = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [OUT_W-1:0]     rsp_out_byte;

   // predictor state
   logic [KEY_W-1:0] key_bank   = '0;
   logic [LEN_W-1:0] key_span   = 4'd1;
   logic             decrypt_on = 1'b0;
   logic [POS_W-1:0] key_index  = '0;

   logic [OUT_W-1:0] pending_letters [$];
   logic [OUT_W-1:0] oldest_letter;
   plan_row_type     plan [$];

   int error_count = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int pop_hold    = 0;
   logic [1:0] pop_mode = 2'd0;

   repeating_key_letter_cipher_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_in_byte       (req_in_byte),
      .req_message_start (req_message_start),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_repeating_key_letter_cipher_unit: errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   // Advance the key position for one request; returns 1 when a letter comes out.
   function automatic bit shift_letter(input logic [BYTE_W-1:0] b, input logic start,
                                       output logic [OUT_W-1:0] letter_out);
      int m, k, r, span, pos;
      letter_out = '0;
      if (start) key_index = '0;
      if (b >= ASCII_UP_A && b <= ASCII_UP_Z) m = int'(b) - int'(ASCII_UP_A);
      else if (b >= ASCII_LO_A && b <= ASCII_LO_Z) m = int'(b) - int'(ASCII_LO_A);
      else return 1'b0;
      span = int'(key_span);
      if (span == 0) span = 1;
      if (span > KEY_MAX) span = KEY_MAX;
      pos = int'(key_index);
      if (pos >= span) pos = 0;
      k = int'(key_bank[pos*LETTER_W +: LETTER_W]);
      if (k >= int'(ALPHA)) k -= int'(ALPHA);
      if (decrypt_on) r = (m + int'(ALPHA) - k) % int'(ALPHA);
      else r = (m + k) % int'(ALPHA);
      pos++;
      if (pos >= span) pos = 0;
      key_index = POS_W'(pos);
      letter_out = OUT_W'(int'(ASCII_LO_A) + r);
      return 1'b1;
   endfunction

   function automatic plan_row_type write_row(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [KEY_W-1:0] data);
      plan_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.idx = idx;
      row.wdata = data;
      return row;
   endfunction

   function automatic plan_row_type byte_row(input logic [BYTE_W-1:0] b, input logic start);
      plan_row_type row;
      row = '0;
      row.in_byte = b;
      row.start = start;
      return row;
   endfunction

   function automatic plan_row_type typed_row(input logic [BYTE_W-1:0] b, input logic start,
                                              input logic yields, input logic [OUT_W-1:0] o);
      plan_row_type row;
      row = byte_row(b, start);
      row.typed = 1'b1;
      row.yields = yields;
      row.out_byte = o;
      return row;
   endfunction

   // Leaves csr_valid high; the caller drops it after the last write of a group.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         CSR_KEY_LETTERS:  key_bank = data;
         CSR_KEY_LENGTH:   key_span = data[LEN_W-1:0];
         CSR_DECRYPT_MODE: decrypt_on = data[0];
         default: ;
      endcase
   endtask

   task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic start,
                             output bit produced, output logic [OUT_W-1:0] letter);
      int gap;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 40));
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_in_byte <= b;
      req_message_start <= start;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full !== 1'b0) @(posedge clock);
      produced = shift_letter(b, start, letter);
   endtask

   // Hold the sender until every expected letter has been popped.
   task automatic wait_for_drain();
      int waited;
      waited = 0;
      req_push <= 1'b0;
      while (pending_letters.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      if (pending_letters.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_letters.size()));
         pending_letters.delete();
      end
   endtask

   // Receiver: switch between always-pop, coin-flip, full stall and a sparse periodic pop.
   always @(posedge clock) begin
      if (pop_hold == 0) begin
         pop_mode <= 2'($urandom_range(0, 3));
         pop_hold <= int'($urandom_range(1, 60));
      end else begin
         pop_hold <= pop_hold - 1;
      end
      case (pop_mode)
         2'd0: rsp_pop <= 1'b1;
         2'd1: rsp_pop <= 1'($urandom_range(0, 1));
         2'd2: rsp_pop <= 1'b0;
         default: rsp_pop <= (cycle_count % 3 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop === 1'b1 && rsp_empty === 1'b0) begin
         if (pending_letters.size() == 0) begin
            report_mismatch($sformatf("unexpected out_byte %h", rsp_out_byte));
         end else begin
            oldest_letter = pending_letters.pop_front();
            if (rsp_out_byte !== oldest_letter)
               report_mismatch($sformatf("out_byte %h, expected %h",
                                         rsp_out_byte, oldest_letter));
         end
      end
   end

   initial begin
      bit               produced;
      logic [OUT_W-1:0] letter;
      logic [BYTE_W-1:0] b;
      logic             start;
      logic [KEY_W-1:0] data;
      int letters, msg_len, pick, span, phase;
      bit fresh;

      // after reset: key letter 0, length 1, encrypt, so letters map to their lower case
      plan.push_back(typed_row(8'h41, 1'b0, 1'b1, 7'h61));   // A
      plan.push_back(typed_row(8'h5A, 1'b0, 1'b1, 7'h7A));   // Z
      plan.push_back(typed_row(8'h61, 1'b0, 1'b1, 7'h61));   // a
      plan.push_back(typed_row(8'h7A, 1'b0, 1'b1, 7'h7A));   // z
      plan.push_back(write_row(CSR_SPARE, KEY_ONES));
      plan.push_back(typed_row(8'h00, 1'b1, 1'b0, 7'h00));
      plan.push_back(typed_row(8'hFF, 1'b0, 1'b0, 7'h00));
      // neighbors of both letter ranges
      plan.push_back(typed_row(8'h40, 1'b0, 1'b0, 7'h00));
      plan.push_back(typed_row(8'h5B, 1'b0, 1'b0, 7'h00));
      plan.push_back(typed_row(8'h60, 1'b0, 1'b0, 7'h00));
      plan.push_back(typed_row(8'h7B, 1'b0, 1'b0, 7'h00));
      // four-letter key with the out-of-range letters 31 and 26
      plan.push_back(write_row(CSR_KEY_LETTERS, KEY_MIX));
      plan.push_back(write_row(CSR_KEY_LENGTH, 60'd4));
      plan.push_back(typed_row(8'h61, 1'b1, 1'b1, 7'h7A));
      plan.push_back(byte_row(8'h61, 1'b0));
      plan.push_back(byte_row(8'h61, 1'b0));
      plan.push_back(byte_row(8'h61, 1'b0));
      plan.push_back(byte_row(8'h61, 1'b0));
      // restart flag on a dropped byte still rewinds the key
      plan.push_back(byte_row(8'h21, 1'b1));
      plan.push_back(byte_row(8'h61, 1'b0));
      plan.push_back(write_row(CSR_DECRYPT_MODE, 60'd1));
      plan.push_back(byte_row(8'h41, 1'b1));
      // zero length acts as one
      plan.push_back(write_row(CSR_KEY_LENGTH, 60'd0));
      plan.push_back(byte_row(8'h6D, 1'b1));
      // length above the maximum saturates; all-ones letters reduce to 5
      plan.push_back(write_row(CSR_KEY_LENGTH, 60'd15));
      plan.push_back(write_row(CSR_KEY_LETTERS, KEY_ONES));
      plan.push_back(byte_row(8'h71, 1'b1));
      plan.push_back(byte_row(8'h72, 1'b0));
      plan.push_back(byte_row(8'h73, 1'b0));
      plan.push_back(byte_row(8'h74, 1'b0));
      // shrink the key below the current position
      plan.push_back(write_row(CSR_KEY_LETTERS, KEY_MIX));
      plan.push_back(write_row(CSR_KEY_LENGTH, 60'd2));
      plan.push_back(write_row(CSR_DECRYPT_MODE, 60'd0));
      plan.push_back(byte_row(8'h75, 1'b0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            if (i == 0 || !plan[i-1].is_write) wait_for_drain();
            csr_write(plan[i].idx, plan[i].wdata);
            if (i == plan.size() - 1 || !plan[i+1].is_write) csr_valid <= 1'b0;
         end else begin
            offer_byte(plan[i].in_byte, plan[i].start, produced, letter);
            if (plan[i].typed) begin
               if (plan[i].yields) pending_letters.push_back(plan[i].out_byte);
            end else if (produced) begin
               pending_letters.push_back(letter);
            end
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_for_drain();
         case (phase)
            0: begin
               csr_write(CSR_KEY_LETTERS, '0);
               csr_write(CSR_KEY_LENGTH, 60'd1);
               csr_write(CSR_DECRYPT_MODE, 60'd0);
            end
            1: begin
               csr_write(CSR_KEY_LETTERS, KEY_ONES);
               csr_write(CSR_KEY_LENGTH, 60'd12);
               csr_write(CSR_DECRYPT_MODE, 60'd1);
            end
            default: begin
               data = '0;
               for (int j = 0; j < KEY_MAX; j++) begin
                  pick = ($urandom_range(0, 3) == 0) ? int'($urandom_range(26, 31))
                                                     : int'($urandom_range(0, 25));
                  data[j*LETTER_W +: LETTER_W] = LETTER_W'(pick);
               end
               if ($urandom_range(0, 7) == 0) data = KEY_W'({$urandom, $urandom});
               csr_write(CSR_KEY_LETTERS, data);
               if ($urandom_range(0, 5) == 0) begin
                  span = int'($urandom_range(0, 3));
                  if (span != 0) span += 12;
               end else begin
                  span = int'($urandom_range(1, 12));
               end
               // upper bits of the length and mode writes carry junk
               data = KEY_W'({$urandom, $urandom});
               data[LEN_W-1:0] = LEN_W'(span);
               csr_write(CSR_KEY_LENGTH, data);
               data = KEY_W'({$urandom, $urandom});
               csr_write(CSR_DECRYPT_MODE, data);
            end
         endcase
         csr_valid <= 1'b0;

         letters = 0;
         while (letters < PHASE_LETTERS) begin
            msg_len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(30, 80))
                                                 : int'($urandom_range(1, 20));
            fresh = ($urandom_range(0, 9) != 0);
            for (int j = 0; j < msg_len; j++) begin
               pick = int'($urandom_range(0, 99));
               if (pick < 45) b = ASCII_UP_A + 8'($urandom_range(0, 25));
               else if (pick < 85) b = ASCII_LO_A + 8'($urandom_range(0, 25));
               else if (pick < 93) b = 8'($urandom_range(32, 64));
               else b = 8'($urandom_range(0, 255));
               start = (j == 0) ? fresh : ($urandom_range(0, 63) == 0);
               offer_byte(b, start, produced, letter);
               if (produced) begin
                  pending_letters.push_back(letter);
                  letters++;
               end
            end
            if ($urandom_range(0, 40) == 0) wait_for_drain();
         end
      end

      wait_for_drain();
      if (error_count == 0)
         $display("tb_repeating_key_letter_cipher_unit: clean");
      else
         $display("tb_repeating_key_letter_cipher_unit: errors");
      $finish;
   end

endmodule
